// ===== rtl/qtmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qtmb_pkg;

  // Field widths of the item.
  localparam int Q_W   = 16;
  localparam int POS_W = 32;
  localparam int OUT_W = 32;

  // Rounded rotation entries, Q8.16, always fit in 30 signed bits.
  localparam int M_W = 30;

  // Number of matrix entries in the 3x3 part.
  localparam int NUM_M = 9;

  typedef logic signed [Q_W-1:0]   q16_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [M_W-1:0]   ment_t;

  typedef struct packed {
    q16_t w;
    q16_t z;
    q16_t y;
    q16_t x;
  } quat_t;

  typedef struct packed {
    q16_t z;
    q16_t y;
    q16_t x;
  } scale_t;

  // Fields of an item that ride along with the rotation math.
  typedef struct packed {
    logic opcode;
    pos_t pos_z;
    pos_t pos_y;
    pos_t pos_x;
  } side_t;

  // Opcode values.
  localparam logic OP_OBJECT = 1'b0;
  localparam logic OP_CAMERA = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/qtmb_rot_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-stage pipeline from quaternion and scale to the rounded, scaled
// rotation entries m[r*3+c]: doubled products, rotation terms, scale
// multiply, round to Q8.16.
module qtmb_rot_core
  import qtmb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire quat_t        in_quat,
  input  wire scale_t       in_scale,
  input  wire side_t        in_side,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ment_t [NUM_M-1:0] out_m,
  output side_t             out_side
);

  localparam int PROD_W = 2 * Q_W + 1;
  localparam int ROT_W  = PROD_W + 1;
  localparam int SCL_W  = ROT_W + Q_W;
  localparam int FRAC_SHIFT = 20;

  localparam logic signed [ROT_W-1:0] ONE = ROT_W'(64'sd268435456);
  localparam logic signed [SCL_W-1:0] HALF = SCL_W'(64'sd524288);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: doubled quaternion products.
  logic signed [2*Q_W-1:0] p_xx, p_xy, p_xz, p_xw, p_yy, p_yz, p_yw, p_zz, p_zw;
  logic signed [PROD_W-1:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;
  scale_t scl1;
  side_t  side1;

  assign p_xx = in_quat.x * in_quat.x;
  assign p_xy = in_quat.x * in_quat.y;
  assign p_xz = in_quat.x * in_quat.z;
  assign p_xw = in_quat.x * in_quat.w;
  assign p_yy = in_quat.y * in_quat.y;
  assign p_yz = in_quat.y * in_quat.z;
  assign p_yw = in_quat.y * in_quat.w;
  assign p_zz = in_quat.z * in_quat.z;
  assign p_zw = in_quat.z * in_quat.w;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx <= {p_xx, 1'b0};
      xy <= {p_xy, 1'b0};
      xz <= {p_xz, 1'b0};
      xw <= {p_xw, 1'b0};
      yy <= {p_yy, 1'b0};
      yz <= {p_yz, 1'b0};
      yw <= {p_yw, 1'b0};
      zz <= {p_zz, 1'b0};
      zw <= {p_zw, 1'b0};
      scl1  <= in_scale;
      side1 <= in_side;
    end
  end

  // Stage 2: rotation terms in Q.28, row-major.
  logic signed [ROT_W-1:0] rot2 [NUM_M];
  q16_t  scl2 [3];
  side_t side2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rot2[0] <= ONE - ROT_W'(yy) - ROT_W'(zz);
      rot2[1] <= ROT_W'(xy) - ROT_W'(zw);
      rot2[2] <= ROT_W'(xz) + ROT_W'(yw);
      rot2[3] <= ROT_W'(xy) + ROT_W'(zw);
      rot2[4] <= ONE - ROT_W'(xx) - ROT_W'(zz);
      rot2[5] <= ROT_W'(yz) - ROT_W'(xw);
      rot2[6] <= ROT_W'(xz) - ROT_W'(yw);
      rot2[7] <= ROT_W'(yz) + ROT_W'(xw);
      rot2[8] <= ONE - ROT_W'(xx) - ROT_W'(yy);
      scl2[0] <= scl1.x;
      scl2[1] <= scl1.y;
      scl2[2] <= scl1.z;
      side2   <= side1;
    end
  end

  // Stage 3: each term times the scale of its column, exact in Q.36.
  logic signed [SCL_W-1:0] sp3 [NUM_M];
  side_t side3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < NUM_M; k++) begin
        sp3[k] <= SCL_W'(rot2[k]) * SCL_W'(scl2[k % 3]);
      end
      side3 <= side2;
    end
  end

  // Stage 4: round half up to Q8.16.
  logic signed [SCL_W-1:0] rsum [NUM_M];

  always_comb begin
    for (int k = 0; k < NUM_M; k++) begin
      rsum[k] = sp3[k] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < NUM_M; k++) begin
        out_m[k] <= rsum[k][FRAC_SHIFT +: M_W];
      end
      out_side <= side3;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

// ===== rtl/quaternion_transform_matrix_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the master side takes results; every
// stage has its own valid bit, so the pipeline keeps accepting while a finished
// matrix waits to be taken, until all of its stages are full.
// Reset: rst (synchronous, active high) clears all valid bits; data registers are not reset.

// Builds a 3x4 affine matrix from a quaternion, a per-axis scale and a position.
// Stages 1 to 4 live in the rotation core (doubled quaternion products,
// rotation terms, scale multiply, rounding to Q8.16). Stage 5 multiplies the
// position by the rounded entries, stage 6 sums each row, and stage 7 rounds
// and saturates the camera translation and drives the output register.
// In object mode the 3x3 part is passed as is and the position is the
// translation. In camera mode the 3x3 part is transposed and each translation
// component is the negated dot product of the position with a row of the
// entries before the transpose.
module quaternion_transform_matrix_builder
  import qtmb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z (16 bits each),
  // then pos_x, pos_y, pos_z (32 bits each).
  input  wire logic [207:0] s_axis_tdata,
  // opcode
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // e_00, e_10, e_20, e_01, e_11, e_21, e_02, e_12, e_22, t_0, t_1, t_2
  // (32 bits each).
  output logic [383:0]      m_axis_tdata
);

  localparam int PR_W  = POS_W + M_W;
  localparam int SUM_W = 64;
  localparam int RND_SHIFT = 16;
  localparam int PIPE_DEPTH = 7;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd32768);

  // Input unpacking.
  quat_t  in_quat;
  scale_t in_scale;
  side_t  in_side;

  assign in_quat.x  = s_axis_tdata[15:0];
  assign in_quat.y  = s_axis_tdata[31:16];
  assign in_quat.z  = s_axis_tdata[47:32];
  assign in_quat.w  = s_axis_tdata[63:48];
  assign in_scale.x = s_axis_tdata[79:64];
  assign in_scale.y = s_axis_tdata[95:80];
  assign in_scale.z = s_axis_tdata[111:96];
  assign in_side.pos_x  = s_axis_tdata[143:112];
  assign in_side.pos_y  = s_axis_tdata[175:144];
  assign in_side.pos_z  = s_axis_tdata[207:176];
  assign in_side.opcode = s_axis_tuser[0];

  // Rotation core, stages 1 to 4.
  logic              core_valid;
  logic              core_ready;
  ment_t [NUM_M-1:0] core_m;
  side_t             core_side;

  qtmb_rot_core u_rot_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_quat   (in_quat),
    .in_scale  (in_scale),
    .in_side   (in_side),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_m     (core_m),
    .out_side  (core_side)
  );

  // Ready chain of the back stages. A stage loads whenever it is empty or the
  // stage after it moves on.
  logic v5, v6, v7;
  logic rdy5, rdy6, rdy7;

  assign rdy7 = !v7 || m_axis_tready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign core_ready = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= core_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // Stage 5: position component c times entry m[r][c], exact in Q.32.
  logic signed [PR_W-1:0] pr5 [NUM_M];
  ment_t                  m5 [NUM_M];
  side_t                  side5;
  pos_t                   pos_c [3];

  assign pos_c[0] = core_side.pos_x;
  assign pos_c[1] = core_side.pos_y;
  assign pos_c[2] = core_side.pos_z;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int k = 0; k < NUM_M; k++) begin
        pr5[k] <= PR_W'(pos_c[k % 3]) * PR_W'(core_m[k]);
        m5[k]  <= core_m[k];
      end
      side5 <= core_side;
    end
  end

  // Stage 6: row sums of the products.
  logic signed [SUM_W-1:0] sum6 [3];
  ment_t                   m6 [NUM_M];
  side_t                   side6;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      for (int r = 0; r < 3; r++) begin
        sum6[r] <= SUM_W'(pr5[3 * r]) + SUM_W'(pr5[3 * r + 1]) + SUM_W'(pr5[3 * r + 2]);
      end
      m6    <= m5;
      side6 <= side5;
    end
  end

  // Stage 7: negate, round half up to Q16.16 and saturate. The value fits in
  // 32 bits exactly when the bits from the sign of the 32-bit result upward
  // all agree.
  logic signed [SUM_W-1:0] rnd [3];
  logic [OUT_W-1:0]        cam_t [3];
  logic [OUT_W-1:0]        t_sel [3];
  logic [OUT_W-1:0]        e_sel [NUM_M];

  localparam int SAT_LSB = RND_SHIFT + OUT_W - 1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = HALF - sum6[r];
      if (&rnd[r][SUM_W-1:SAT_LSB] || !(|rnd[r][SUM_W-1:SAT_LSB])) begin
        cam_t[r] = rnd[r][RND_SHIFT +: OUT_W];
      end else if (rnd[r][SUM_W-1]) begin
        cam_t[r] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        cam_t[r] = {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
    t_sel[0] = (side6.opcode == OP_CAMERA) ? cam_t[0] : side6.pos_x;
    t_sel[1] = (side6.opcode == OP_CAMERA) ? cam_t[1] : side6.pos_y;
    t_sel[2] = (side6.opcode == OP_CAMERA) ? cam_t[2] : side6.pos_z;
    // Output field j is row j%3, column j/3. Object mode reads m[r][c],
    // camera mode the transpose m[c][r], which is m[j] in row-major order.
    for (int j = 0; j < NUM_M; j++) begin
      if (side6.opcode == OP_CAMERA) begin
        e_sel[j] = OUT_W'(m6[j]);
      end else begin
        e_sel[j] = OUT_W'(m6[(j % 3) * 3 + j / 3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      for (int j = 0; j < NUM_M; j++) begin
        m_axis_tdata[OUT_W * j +: OUT_W] <= e_sel[j];
      end
      for (int r = 0; r < 3; r++) begin
        m_axis_tdata[OUT_W * (NUM_M + r) +: OUT_W] <= t_sel[r];
      end
    end
  end

  assign m_axis_tvalid = v7;

  // Items in flight, kept to check that none is lost or repeated.
  logic [3:0] inflight;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_fire && !out_fire) begin
      inflight <= inflight + 4'd1;
    end else if (out_fire && !in_fire) begin
      inflight <= inflight - 4'd1;
    end
  end

  // A taken output always frees the whole pipeline for a new item.
  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output was taken");

  // The pipeline never holds more items than it has stages.
  a_depth : assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // No result is shown without an item in flight.
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    (inflight == 4'd0) |-> !m_axis_tvalid)
    else $error("result shown with no item in flight");

  // The rotation core holds its result while the back stages stall.
  a_core_hold : assert property (@(posedge clk) disable iff (rst)
    core_valid && !core_ready |=> core_valid)
    else $error("rotation core dropped a stalled result");

endmodule

`default_nettype wire

// ===== test/quaternion_transform_matrix_builder_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the quaternion transform matrix builder. A pose item
// (quaternion, per-axis scale, position and opcode) goes in on the slave side.
// One packed 3x4 matrix comes out on the master side for every item. The
// matrix book below predicts each matrix in exact 64-bit integer arithmetic.
// It checks every result, entry by entry, against the oldest prediction.
module quaternion_transform_matrix_builder_tb;
  import qtmb_pkg::*;

  localparam int NUM_RANDOM  = 1000;
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off to back up the pipe
  localparam int HOLD_AFTER  = 300;      // accepted items before the hold-off starts
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN       = 20;       // margin after the last matrix is checked
  localparam longint ONE_Q28 = 64'sd1 <<< 28;
  localparam longint HALF_Q36 = 64'sd1 <<< 19;
  localparam longint HALF_Q32 = 64'sd1 <<< 15;
  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;

  // One pose item as the block sees it.
  typedef struct {
    logic opcode;
    q16_t qx, qy, qz, qw;
    q16_t sx, sy, sz;
    pos_t px, py, pz;
  } pose_t;

  // e_00 e_10 e_20 e_01 e_11 e_21 e_02 e_12 e_22 t_0 t_1 t_2, entry 0 in the low bits,
  // which is exactly the layout of m_axis_tdata.
  typedef logic [11:0][31:0] matrix_t;

  // Holds the matrices still owed by the block and checks each one that arrives.
  class matrix_book;
    matrix_t owed_q[$];
    int      mismatches = 0;
    string   entry_names [12] = '{"e_00", "e_10", "e_20", "e_01", "e_11", "e_21",
                                  "e_02", "e_12", "e_22", "t_0", "t_1", "t_2"};

    // Scale times rotation term is exact in Q.36; round half up to Q8.16.
    function longint round_entry(longint scale, longint rot);
      return (scale * rot + HALF_Q36) >>> 20;
    endfunction

    // Negated dot product in Q.32, rounded half up to Q16.16 and saturated.
    function longint camera_shift(longint px, longint py, longint pz,
                                  longint a, longint b, longint c);
      longint sum;
      sum = -(px * a + py * b + pz * c);
      sum = (sum + HALF_Q32) >>> 16;
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      return sum;
    endfunction

    function matrix_t build_matrix(pose_t p);
      longint qx, qy, qz, qw, sx, sy, sz, px, py, pz;
      longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
      longint m [3][3];
      matrix_t res;
      qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
      sx = p.sx; sy = p.sy; sz = p.sz;
      px = p.px; py = p.py; pz = p.pz;
      xx = 2 * qx * qx; xy = 2 * qx * qy; xz = 2 * qx * qz;
      xw = 2 * qx * qw; yy = 2 * qy * qy; yz = 2 * qy * qz;
      yw = 2 * qy * qw; zz = 2 * qz * qz; zw = 2 * qz * qw;
      // Column c of the rotation carries the scale of axis c.
      m[0][0] = round_entry(sx, ONE_Q28 - yy - zz);
      m[1][0] = round_entry(sx, xy + zw);
      m[2][0] = round_entry(sx, xz - yw);
      m[0][1] = round_entry(sy, xy - zw);
      m[1][1] = round_entry(sy, ONE_Q28 - xx - zz);
      m[2][1] = round_entry(sy, yz + xw);
      m[0][2] = round_entry(sz, xz + yw);
      m[1][2] = round_entry(sz, yz - xw);
      m[2][2] = round_entry(sz, ONE_Q28 - xx - yy);
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          // Camera mode shows the transpose.
          if (p.opcode == OP_CAMERA) res[c * 3 + r] = m[c][r][31:0];
          else res[c * 3 + r] = m[r][c][31:0];
        end
      end
      if (p.opcode == OP_CAMERA) begin
        // Translation rows use the entries before the transpose.
        for (int r = 0; r < 3; r++)
          res[9 + r] = 32'(camera_shift(px, py, pz, m[r][0], m[r][1], m[r][2]));
      end else begin
        res[9]  = p.px;
        res[10] = p.py;
        res[11] = p.pz;
      end
      return res;
    endfunction

    function void note_pose(pose_t p);
      owed_q.push_back(build_matrix(p));
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      if (owed_q.size() == 0) begin
        $error("matrix arrived with none owed: %h", got);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got[i] !== want[i]) begin
          $error("%s expected %0d actual %0d", entry_names[i],
                 $signed(want[i]), $signed(got[i]));
          mismatches++;
        end
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  wire          s_axis_tready;
  logic [207:0] s_axis_tdata;   // quat_x..w, scale_x..z (16 each), pos_x..z (32 each)
  logic [0:0]   s_axis_tuser;   // opcode
  wire          m_axis_tvalid;
  logic         m_axis_tready;
  wire  [383:0] m_axis_tdata;   // e_00 e_10 e_20 e_01 e_11 e_21 e_02 e_12 e_22 t_0 t_1 t_2

  matrix_book book = new();
  int poses_accepted = 0;

  quaternion_transform_matrix_builder u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Idle stretches: mostly short ones, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Random 16-bit field: full range most of the time, with extremes and small
  // values mixed in so that boundaries and near-zero products show up often.
  function automatic q16_t rand_q16();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2: v = $urandom_range(0, 600) - 300;
      default: v = $urandom;
    endcase
    return q16_t'(v);
  endfunction

  function automatic pos_t rand_pos();
    pos_t v;
    case ($urandom_range(0, 7))
      0: v = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1, 2: v = pos_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic pose_t make_pose(logic op, int qx, int qy, int qz, int qw,
                                      int sx, int sy, int sz,
                                      int px, int py, int pz);
    pose_t p;
    p.opcode = op;
    p.qx = q16_t'(qx); p.qy = q16_t'(qy); p.qz = q16_t'(qz); p.qw = q16_t'(qw);
    p.sx = q16_t'(sx); p.sy = q16_t'(sy); p.sz = q16_t'(sz);
    p.px = px; p.py = py; p.pz = pz;
    return p;
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.opcode = ($urandom_range(0, 1) != 0) ? OP_CAMERA : OP_OBJECT;
    p.qx = rand_q16(); p.qy = rand_q16(); p.qz = rand_q16(); p.qw = rand_q16();
    p.sx = rand_q16(); p.sy = rand_q16(); p.sz = rand_q16();
    p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
    return p;
  endfunction

  // Offers one pose until the block takes it, then maybe idles the slave side.
  // idle_mode 0 never idles, 1 idles now and then, 2 idles often.
  task automatic send_pose(input pose_t p, input int idle_mode);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.pz, p.py, p.px, p.sz, p.sy, p.sx, p.qw, p.qz, p.qy, p.qx};
    s_axis_tuser  <= p.opcode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_pose(p);
    poses_accepted++;
    gap = 0;
    if (idle_mode == 1 && $urandom_range(0, 9) == 0) gap = gap_length();
    if (idle_mode == 2 && $urandom_range(0, 1) == 0) gap = gap_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Master side: checks each taken matrix and paces tready. The stall rate is
  // picked again and again, so some stretches never stall. Once a few
  // hundred items are in, tready is held low for a long stretch while the
  // sender keeps offering, so the pipeline fills and stalls its input.
  initial begin : sink
    int quiet;
    int stall_pct;
    int cyc;
    bit held;
    quiet = 0;
    stall_pct = 0;
    cyc = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) book.check_matrix(m_axis_tdata);
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      cyc++;
      if (quiet > 0) quiet--;
      else if (!held && poses_accepted >= HOLD_AFTER) begin
        quiet = HOLD_CYCLES;
        held = 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) quiet = gap_length();
      m_axis_tready <= (quiet == 0);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int idle_mode;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Identity rotation with unit scale, in both modes, and an all-zero pose.
    send_pose(make_pose(OP_OBJECT, 0, 0, 0, 16384, 256, 256, 256, 65536, -65536, 0), 0);
    send_pose(make_pose(OP_CAMERA, 0, 0, 0, 16384, 256, 256, 256, 65536, -65536, 0), 0);
    send_pose(make_pose(OP_OBJECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // Most negative and most positive fields everywhere.
    send_pose(make_pose(OP_OBJECT, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000), 1);
    send_pose(make_pose(OP_CAMERA, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000), 1);
    send_pose(make_pose(OP_OBJECT, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1);
    // Camera translation driven into both saturation limits.
    send_pose(make_pose(OP_CAMERA, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1);
    send_pose(make_pose(OP_CAMERA, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1);
    // Quarter turn about z, rigid camera with an ordinary position.
    send_pose(make_pose(OP_CAMERA, 0, 0, 11585, 11585, 256, 256, 256,
                        3 * 65536, -5 * 65536, 7 * 65536), 0);
    // Negative and zero scale are used as given.
    send_pose(make_pose(OP_OBJECT, 0, 11585, 0, 11585, -256, 0, -512, 1, -1, 2), 0);
    send_pose(make_pose(OP_CAMERA, 0, 11585, 0, 11585, -256, 0, -512, 1, -1, 2), 0);
    // Quaternion of twice unit length is not normalized.
    send_pose(make_pose(OP_OBJECT, 0, 0, 0, 32767, 256, 256, 256, 0, 0, 0), 0);
    send_pose(make_pose(OP_CAMERA, 16384, 16384, 16384, 16384, 256, 256, 256,
                        65536, 65536, 65536), 0);
    // Rounding ties on the entries: +1/2 rounds up, -1/2 rounds up to zero.
    send_pose(make_pose(OP_OBJECT, 512, 512, 0, 0, 1, 1, 1, 0, 0, 0), 0);
    send_pose(make_pose(OP_OBJECT, 512, -512, 0, 0, 1, 1, 1, 0, 0, 0), 0);
    // Rounding ties on the camera translation.
    send_pose(make_pose(OP_CAMERA, 0, 0, 0, 0, 16, 16, 16, 8, 0, 0), 0);
    send_pose(make_pose(OP_CAMERA, 0, 0, 0, 0, 16, 16, 16, -8, 0, 0), 0);

    idle_mode = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) idle_mode = $urandom_range(0, 2);
      send_pose(random_pose(), idle_mode);
    end
    s_axis_tvalid <= 1'b0;

    while (book.owed() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (book.mismatches == 0 && book.owed() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== quaternion_transform_matrix_builder.f =====
rtl/qtmb_pkg.sv
rtl/qtmb_rot_core.sv
rtl/quaternion_transform_matrix_builder.sv
test/quaternion_transform_matrix_builder_tb.sv
